[hw/rtl/nras_pkg.sv]
package nras_pkg;

  localparam int unsigned VOXEL_W  = 16;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned MSE_W    = 48;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned ACT_W    = 32;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned PTS_W    = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUISANCE_MASK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_POINTS = 1'b1;

  // one finished voxel handed from the front to the back
  typedef struct packed {
    logic signed [ACC_W-1:0] error;
    logic [MSE_W-1:0]        mse;
  } voxel_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hw/rtl/nras_front.sv]
module nras_front import nras_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VOXEL_W-1:0] voxel_value,
  input  logic [COL_W-1:0]         column_index,
  input  logic signed [COEF_W-1:0] beta_value,
  input  logic signed [COEF_W-1:0] design_value,
  input  logic [MSE_W-1:0]         residual_mse,
  input  logic                     last_column,
  input  logic [MASK_W-1:0]        nuisance_mask,
  input  queue_status_t            q_status,
  output logic                     push,
  output voxel_entry_t             push_entry
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ACC  = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic signed [VOXEL_W-1:0] voxel_r;
  logic [COL_W-1:0]          col_r;
  logic signed [COEF_W-1:0]  beta_r, design_r;
  logic [MSE_W-1:0]          mse_r;
  logic                      last_r;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  logic signed [ACC_W-1:0] base, sub;
  logic signed [ACC_W:0]   diff;
  logic                    nuis;
  logic                    acc_go;

  assign in_ready = (state_r == F_IDLE);
  assign acc_go   = (state_r == F_ACC) && !(last_r && q_status.full);

  always_comb begin
    base = (col_r == '0) ? (ACC_W'(voxel_r) <<< FRACTION_BITS) : acc_r;
    sub  = prod_r >>> FRACTION_BITS;
    diff = {base[ACC_W-1], base} - {sub[ACC_W-1], sub};
    nuis = (32'(col_r) < MAX_COLUMNS) && nuisance_mask[col_r];
    acc_nxt = base;
    if (nuis) begin
      if (diff[ACC_W] != diff[ACC_W-1]) begin
        acc_nxt = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt = diff[ACC_W-1:0];
      end
    end
  end

  assign push             = acc_go && last_r;
  assign push_entry.error = acc_nxt;
  assign push_entry.mse   = mse_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_ACC;
      F_ACC:  if (acc_go) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_go) acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      voxel_r  <= voxel_value;
      col_r    <= column_index;
      beta_r   <= beta_value;
      design_r <= design_value;
      mse_r    <= residual_mse;
      last_r   <= last_column;
    end
    if (state_r == F_MUL) prod_r <= ACC_W'(beta_r) * ACC_W'(design_r);
  end

endmodule

[hw/rtl/nras_queue.sv]
module nras_queue import nras_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  voxel_entry_t  push_entry,
  input  logic          pop,
  output voxel_entry_t  pop_entry,
  output queue_status_t status
);

  voxel_entry_t mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign pop_entry    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

[hw/rtl/nras_back.sv]
module nras_back import nras_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  queue_status_t           q_status,
  input  voxel_entry_t            pop_entry,
  output logic                    pop,
  input  logic [PTS_W-1:0]        residual_points,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACT_W-1:0] activation,
  output logic                    deviation_zero
);

  localparam int unsigned SQ_STEPS = (MSE_W + FRACTION_BITS + 1) / 2;
  localparam int unsigned RAD_W    = 2 * SQ_STEPS;
  localparam int unsigned REM_W    = SQ_STEPS + 2;
  localparam int unsigned QB       = ACT_W - 1;
  localparam int unsigned CNT_W    = 6;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_VAR   = 6'b000010,
    B_SQRT  = 6'b000100,
    B_CHECK = 6'b001000,
    B_DIV   = 6'b010000,
    B_DONE  = 6'b100000
  } back_state_t;

  back_state_t state_r;

  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        mag_r;
  logic [MSE_W-1:0]        vq_r;
  logic [PTS_W:0]          vrem_r;
  logic [RAD_W-1:0]        rad_r;
  logic [REM_W-1:0]        srem_r;
  logic [SQ_STEPS-1:0]     root_r;
  logic [SQ_STEPS-1:0]     drem_r;
  logic [QB-1:0]           dq_r;
  logic signed [ACT_W-1:0] res_act_r;
  logic                    res_dz_r;
  logic                    out_valid_r;

  logic [PTS_W-1:0]      pts;
  logic [PTS_W:0]        vrem_sh;
  logic [REM_W-1:0]      srem_sh, trial;
  logic [SQ_STEPS:0]     drem_sh;
  logic [ACC_W+FRACTION_BITS-1:0] num;
  logic                  err_pos;

  assign pts     = (residual_points == '0) ? PTS_W'(1) : residual_points;
  assign vrem_sh = {vrem_r[PTS_W-1:0], vq_r[MSE_W-1]};
  assign srem_sh = {srem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign drem_sh = {drem_r, dq_r[QB-1]};
  assign num     = {mag_r, {FRACTION_BITS{1'b0}}};
  assign err_pos = !neg_r && (mag_r != '0);

  assign pop            = (state_r == B_IDLE) && !q_status.empty;
  assign out_valid      = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != B_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: if (!q_status.empty) begin
          state_r <= B_VAR;
          cnt_r   <= CNT_W'(MSE_W - 1);
        end
        B_VAR: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= B_SQRT;
            cnt_r   <= CNT_W'(SQ_STEPS - 1);
          end
        end
        B_SQRT: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= B_CHECK;
        end
        B_CHECK: begin
          if (root_r == '0 || mag_r >= (ACC_W'(root_r) << (QB - FRACTION_BITS))) begin
            state_r <= B_DONE;
          end else begin
            state_r <= B_DIV;
            cnt_r   <= CNT_W'(QB - 1);
          end
        end
        B_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= B_DONE;
        end
        B_DONE: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        neg_r  <= pop_entry.error[ACC_W-1];
        mag_r  <= pop_entry.error[ACC_W-1] ? ACC_W'(-pop_entry.error) : pop_entry.error;
        vq_r   <= pop_entry.mse;
        vrem_r <= '0;
      end
      B_VAR: begin
        // restoring divide by the point count, one quotient bit per cycle
        if (vrem_sh >= {1'b0, pts}) begin
          vrem_r <= vrem_sh - {1'b0, pts};
          vq_r   <= {vq_r[MSE_W-2:0], 1'b1};
        end else begin
          vrem_r <= vrem_sh;
          vq_r   <= {vq_r[MSE_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          srem_r <= '0;
          root_r <= '0;
        end
      end
      B_SQRT: begin
        if (srem_sh >= trial) begin
          srem_r <= srem_sh - trial;
          root_r <= {root_r[SQ_STEPS-2:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[SQ_STEPS-2:0], 1'b0};
        end
        rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      end
      B_CHECK: begin
        res_dz_r <= (root_r == '0);
        if (root_r == '0) begin
          res_act_r <= err_pos ? {1'b0, {(ACT_W-1){1'b1}}} :
                       (neg_r ? {1'b1, {(ACT_W-1){1'b0}}} : '0);
        end else begin
          res_act_r <= neg_r ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
        end
        // quotient fits in QB bits here, so the top part is below the divisor
        drem_r <= SQ_STEPS'(num[ACC_W+FRACTION_BITS-1:QB]);
        dq_r   <= num[QB-1:0];
      end
      B_DIV: begin
        if (drem_sh >= {1'b0, root_r}) begin
          drem_r <= SQ_STEPS'(drem_sh - {1'b0, root_r});
          dq_r   <= {dq_r[QB-2:0], 1'b1};
        end else begin
          drem_r <= SQ_STEPS'(drem_sh);
          dq_r   <= {dq_r[QB-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (state_r == B_VAR && cnt_r == '0) begin
      rad_r <= RAD_W'({vq_r[MSE_W-2:0], (vrem_sh >= {1'b0, pts})}) << FRACTION_BITS;
    end
    if (state_r == B_DIV && cnt_r == '0) begin
      res_act_r <= neg_r ? -{1'b0, dq_r[QB-2:0], (drem_sh >= {1'b0, root_r})}
                         :  {1'b0, dq_r[QB-2:0], (drem_sh >= {1'b0, root_r})};
    end
    if (state_r == B_DONE && (!out_valid_r || out_ready)) begin
      activation     <= res_act_r;
      deviation_zero <= res_dz_r;
    end
  end

endmodule

[hw/rtl/nuisance_removed_activation_score.sv]
// Activation score per voxel: one input beat per design column, nuisance columns
// subtract beta * design from the loaded intensity, and the last-column beat queues
// the voxel for error / sqrt(mse / residual_points). Each input beat passes through
// the front's register, multiply and accumulate states, and a last-column beat stays
// in accumulate while the queue is full. The back takes each voxel through a pop
// state, a 48-step divide by the point count, a square root one bit per cycle,
// a range check, a 31-step quotient divide (skipped when the quotient saturates or
// the deviation is zero) and a state to load the result beat.
// A two-entry queue lets the front keep taking columns meanwhile.
module nuisance_removed_activation_score import nras_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VOXEL_W-1:0] in_voxel_value,
  input  logic [COL_W-1:0]         in_column_index,
  input  logic signed [COEF_W-1:0] in_beta_value,
  input  logic signed [COEF_W-1:0] in_design_value,
  input  logic [MSE_W-1:0]         in_residual_mse,
  input  logic                     in_last_column,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACT_W-1:0]  out_activation,
  output logic                     out_deviation_zero
);

  logic [MASK_W-1:0] nuisance_mask_r;
  logic [PTS_W-1:0]  residual_points_r;
  queue_status_t     q_status;
  voxel_entry_t      push_entry, pop_entry;
  logic              push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nuisance_mask_r   <= '0;
      residual_points_r <= PTS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUISANCE_MASK:   nuisance_mask_r   <= cfg_data[MASK_W-1:0];
        REG_RESIDUAL_POINTS: residual_points_r <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  nras_front #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .voxel_value  (in_voxel_value),
    .column_index (in_column_index),
    .beta_value   (in_beta_value),
    .design_value (in_design_value),
    .residual_mse (in_residual_mse),
    .last_column  (in_last_column),
    .nuisance_mask(nuisance_mask_r),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  nras_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .pop_entry (pop_entry),
    .status    (q_status)
  );

  nras_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .residual_points(residual_points_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .activation     (out_activation),
    .deviation_zero (out_deviation_zero)
  );

endmodule

[hw/rtl/nras_checker.sv]
module nras_checker import nras_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ACT_W-1:0] out_activation,
  input logic                    out_deviation_zero
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation)
      && $stable(out_deviation_zero))
    else $error("result beat changed while stalled");

  // zero deviation only ever gives a rail or zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deviation_zero |->
      out_activation == {1'b0, {(ACT_W-1){1'b1}}} ||
      out_activation == {1'b1, {(ACT_W-1){1'b0}}} || out_activation == '0)
    else $error("deviation_zero with non-saturated activation");

  // nothing comes out right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind nuisance_removed_activation_score nras_checker u_nras_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_activation    (out_activation),
  .out_deviation_zero(out_deviation_zero)
);
